@@ rtl/pisc_pkg.sv @@
`default_nettype none
// ============================================================================
// PI speed controller package
// Shared widths, register indexes, queue depths and the structs that travel
// between the register file, the front part and the back part.
// ============================================================================
package pisc_pkg;

    localparam int GAIN_W   = 28;
    localparam int CAP_W    = 39;
    localparam int LIM_W    = 16;
    localparam int TGT_W    = 17;
    localparam int MEAS_W   = 16;
    localparam int ERR_W    = 17;
    localparam int SUM_W    = 40;
    localparam int FRAC_W   = 24;
    localparam int DUTY_W   = 16;

    localparam int DATA_W   = 64;
    localparam int ADDR_W   = 6;
    localparam int IDX_W    = 3;

    localparam int MID_DEPTH = 4;
    localparam int MID_AW    = $clog2(MID_DEPTH);
    localparam int MID_CW    = MID_AW + 1;
    localparam int OUT_DEPTH = 8;
    localparam int OUT_AW    = $clog2(OUT_DEPTH);
    localparam int OUT_CW    = OUT_AW + 1;

    // Register indexes (byte address is 8 times the index).
    localparam logic [IDX_W-1:0] REG_KP         = 3'd0;
    localparam logic [IDX_W-1:0] REG_KI         = 3'd1;
    localparam logic [IDX_W-1:0] REG_CAP        = 3'd2;
    localparam logic [IDX_W-1:0] REG_OUT_MIN    = 3'd3;
    localparam logic [IDX_W-1:0] REG_OUT_MAX    = 3'd4;
    localparam logic [IDX_W-1:0] REG_TARGET_MIN = 3'd5;
    localparam logic [IDX_W-1:0] REG_TARGET_MAX = 3'd6;

    localparam logic [GAIN_W-1:0] KP_RESET  = 28'd1006632;
    localparam logic [GAIN_W-1:0] KI_RESET  = 28'd3355;
    localparam logic [CAP_W-1:0]  CAP_RESET = {CAP_W{1'b1}};

    typedef struct packed {
        logic [GAIN_W-1:0] kp;
        logic [GAIN_W-1:0] ki;
        logic [CAP_W-1:0]  integral_cap;
        logic [LIM_W-1:0]  out_min;
        logic [LIM_W-1:0]  out_max;
        logic [LIM_W-1:0]  target_min;
        logic [LIM_W-1:0]  target_max;
    } t_cfg;

    // One classified item waiting for the back part.
    typedef struct packed {
        logic signed [ERR_W-1:0] err;
        logic signed [SUM_W-1:0] sum;
    } t_work;

endpackage
`default_nettype wire

@@ rtl/pi_speed_controller_top.sv @@
`default_nettype none
// ============================================================================
// PI speed controller, top level
// Takes a target and a measured speed per beat and returns one PWM duty beat
// from a PI law with a saturating, capped integral term.
// ============================================================================
// Usage:
// The input channel is a queue write port: a beat of target_speed and
// measured_speed is taken at each rising edge where push is high and full low.
// The result channel is a queue read port: while empty is low the oldest duty
// sits on o_duty, and it leaves at an edge where pop is high.
// One beat can enter every cycle while full is low, and one duty can leave
// every cycle while pop is high. A duty becomes visible once its beat has
// passed the error register (the error is formed as the beat is taken), the
// error-sum update and the product, shift and clamp stages of the back part.
// The sum update is the only loop, so the rate is one beat per cycle.
// When the receiver stalls, up to eight duties wait in the result queue and
// four more classified beats in the queue between the two parts; full rises
// once those fill, and no beat is ever dropped.
// Reset (synchronous, active low) empties both queues, clears the error sum
// and loads the gains and limits with their reset values. The configuration
// port takes 64-bit writes at byte address 8 times the register index; the
// user must write it only while the block is idle; the block does not check.
// ============================================================================
module pi_speed_controller_top (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // Configuration port
    input  wire                                 psel,
    input  wire                                 penable,
    input  wire                                 pwrite,
    input  wire  [pisc_pkg::ADDR_W-1:0]         paddr,
    input  wire  [pisc_pkg::DATA_W-1:0]         pwdata,
    output logic [pisc_pkg::DATA_W-1:0]         prdata,
    output logic                                pready,
    // Input channel
    input  wire                                 push,
    output logic                                full,
    input  wire  [pisc_pkg::TGT_W-1:0]          i_target_speed,
    input  wire  [pisc_pkg::MEAS_W-1:0]         i_measured_speed,
    // Result channel
    output logic                                empty,
    input  wire                                 pop,
    output logic [pisc_pkg::DUTY_W-1:0]         o_duty
);

    pisc_pkg::t_cfg     w_cfg;
    pisc_pkg::t_work    w_work;
    logic               w_work_valid;
    logic               w_work_pop;

    // Gains and limits; the user changes them only while no beat is in flight, which the block does not enforce.
    pisc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Front part: target clamp, error and the error-sum recurrence.
    pisc_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (w_cfg),
        .i_push           (push),
        .i_target_speed   (i_target_speed),
        .i_measured_speed (i_measured_speed),
        .o_full           (full),
        .o_work_valid     (w_work_valid),
        .o_work           (w_work),
        .i_work_pop       (w_work_pop)
    );

    // Back part: products, shift, output clamp and the result queue.
    pisc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_work_valid (w_work_valid),
        .i_work       (w_work),
        .o_work_pop   (w_work_pop),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_duty       (o_duty)
    );

endmodule
`default_nettype wire

@@ rtl/pisc_regs.sv @@
`default_nettype none
// ============================================================================
// PI speed controller register file
// APB-style configuration registers with read-back.
// ============================================================================
module pisc_regs (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             psel,
    input  wire                             penable,
    input  wire                             pwrite,
    input  wire  [pisc_pkg::ADDR_W-1:0]     paddr,
    input  wire  [pisc_pkg::DATA_W-1:0]     pwdata,
    output logic [pisc_pkg::DATA_W-1:0]     prdata,
    output logic                            pready,
    output pisc_pkg::t_cfg                  o_cfg
);

    pisc_pkg::t_cfg                 r_cfg;
    logic [pisc_pkg::IDX_W-1:0]     w_idx;
    logic                           w_wr;

    assign w_idx  = paddr[pisc_pkg::ADDR_W-1:pisc_pkg::ADDR_W-pisc_pkg::IDX_W];
    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kp           <= pisc_pkg::KP_RESET;
            r_cfg.ki           <= pisc_pkg::KI_RESET;
            r_cfg.integral_cap <= pisc_pkg::CAP_RESET;
            r_cfg.out_min      <= '0;
            r_cfg.out_max      <= '1;
            r_cfg.target_min   <= '0;
            r_cfg.target_max   <= '1;
        end else if (w_wr) begin
            case (w_idx)
                pisc_pkg::REG_KP:         r_cfg.kp <= pwdata[pisc_pkg::GAIN_W-1:0];
                pisc_pkg::REG_KI:         r_cfg.ki <= pwdata[pisc_pkg::GAIN_W-1:0];
                pisc_pkg::REG_CAP:        r_cfg.integral_cap <= pwdata[pisc_pkg::CAP_W-1:0];
                pisc_pkg::REG_OUT_MIN:    r_cfg.out_min <= pwdata[pisc_pkg::LIM_W-1:0];
                pisc_pkg::REG_OUT_MAX:    r_cfg.out_max <= pwdata[pisc_pkg::LIM_W-1:0];
                pisc_pkg::REG_TARGET_MIN: r_cfg.target_min <= pwdata[pisc_pkg::LIM_W-1:0];
                pisc_pkg::REG_TARGET_MAX: r_cfg.target_max <= pwdata[pisc_pkg::LIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            pisc_pkg::REG_KP:
                prdata = {{(pisc_pkg::DATA_W-pisc_pkg::GAIN_W){1'b0}}, r_cfg.kp};
            pisc_pkg::REG_KI:
                prdata = {{(pisc_pkg::DATA_W-pisc_pkg::GAIN_W){1'b0}}, r_cfg.ki};
            pisc_pkg::REG_CAP:
                prdata = {{(pisc_pkg::DATA_W-pisc_pkg::CAP_W){1'b0}}, r_cfg.integral_cap};
            pisc_pkg::REG_OUT_MIN:
                prdata = {{(pisc_pkg::DATA_W-pisc_pkg::LIM_W){1'b0}}, r_cfg.out_min};
            pisc_pkg::REG_OUT_MAX:
                prdata = {{(pisc_pkg::DATA_W-pisc_pkg::LIM_W){1'b0}}, r_cfg.out_max};
            pisc_pkg::REG_TARGET_MIN:
                prdata = {{(pisc_pkg::DATA_W-pisc_pkg::LIM_W){1'b0}}, r_cfg.target_min};
            pisc_pkg::REG_TARGET_MAX:
                prdata = {{(pisc_pkg::DATA_W-pisc_pkg::LIM_W){1'b0}}, r_cfg.target_max};
            default:
                prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/pisc_front.sv @@
`default_nettype none
// ============================================================================
// PI speed controller front part
// Clamps the target, forms the speed error, updates the saturating error sum
// and places the pair in a short queue for the back part.
// ============================================================================
module pisc_front (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire pisc_pkg::t_cfg                 i_cfg,
    input  wire                                 i_push,
    input  wire  [pisc_pkg::TGT_W-1:0]          i_target_speed,
    input  wire  [pisc_pkg::MEAS_W-1:0]         i_measured_speed,
    output logic                                o_full,
    output logic                                o_work_valid,
    output pisc_pkg::t_work                     o_work,
    input  wire                                 i_work_pop
);

    localparam logic signed [pisc_pkg::SUM_W-1:0] SUM_MAX = {1'b0, {(pisc_pkg::SUM_W-1){1'b1}}};
    localparam logic signed [pisc_pkg::SUM_W-1:0] SUM_MIN = {1'b1, {(pisc_pkg::SUM_W-1){1'b0}}};

    logic                                   r_v1;
    logic signed [pisc_pkg::ERR_W-1:0]      r_err;
    logic signed [pisc_pkg::SUM_W-1:0]      r_sum;
    logic signed [pisc_pkg::ERR_W-1:0]      n_err;
    logic signed [pisc_pkg::SUM_W-1:0]      n_sum;

    pisc_pkg::t_work                        r_mid [pisc_pkg::MID_DEPTH];
    logic [pisc_pkg::MID_AW-1:0]            r_wr_ptr;
    logic [pisc_pkg::MID_AW-1:0]            r_rd_ptr;
    logic [pisc_pkg::MID_CW-1:0]            r_count;

    logic                                   w_accept;
    logic                                   w_pop;
    logic signed [pisc_pkg::TGT_W-1:0]      w_tgt;
    logic signed [pisc_pkg::SUM_W:0]        w_wide;
    logic signed [pisc_pkg::SUM_W-1:0]      w_sat;

    // The stage register counts against the queue room so it can always drain.
    assign o_full       = (r_count + {{(pisc_pkg::MID_CW-1){1'b0}}, r_v1})
                          >= pisc_pkg::MID_CW'(pisc_pkg::MID_DEPTH);
    assign w_accept     = i_push & ~o_full;
    assign o_work_valid = (r_count != '0);
    assign o_work       = r_mid[r_rd_ptr];
    assign w_pop        = i_work_pop & o_work_valid;

    // Upper clamp first, then lower, so an inverted range yields target_min.
    always_comb begin
        w_tgt = $signed(i_target_speed);
        if (w_tgt > $signed({1'b0, i_cfg.target_max})) begin
            w_tgt = $signed({1'b0, i_cfg.target_max});
        end
        if (w_tgt < $signed({1'b0, i_cfg.target_min})) begin
            w_tgt = $signed({1'b0, i_cfg.target_min});
        end
        n_err = w_tgt - $signed({1'b0, i_measured_speed});
    end

    // Sum saturates at its width before the cap is applied.
    always_comb begin
        w_wide = {r_sum[pisc_pkg::SUM_W-1], r_sum}
               + {{(pisc_pkg::SUM_W+1-pisc_pkg::ERR_W){r_err[pisc_pkg::ERR_W-1]}}, r_err};
        if (w_wide[pisc_pkg::SUM_W] != w_wide[pisc_pkg::SUM_W-1]) begin
            w_sat = w_wide[pisc_pkg::SUM_W] ? SUM_MIN : SUM_MAX;
        end else begin
            w_sat = w_wide[pisc_pkg::SUM_W-1:0];
        end
        n_sum = w_sat;
        if ((i_cfg.ki != '0) && (w_sat > $signed({1'b0, i_cfg.integral_cap}))) begin
            n_sum = $signed({1'b0, i_cfg.integral_cap});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1     <= 1'b0;
            r_sum    <= '0;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_v1 <= w_accept;
            if (r_v1) begin
                r_sum    <= n_sum;
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (r_v1 && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!r_v1 && w_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_err <= n_err;
        end
        if (r_v1) begin
            r_mid[r_wr_ptr] <= '{err: r_err, sum: n_sum};
        end
    end

endmodule
`default_nettype wire

@@ rtl/pisc_back.sv @@
`default_nettype none
// ============================================================================
// PI speed controller back part
// Two-stage multiply and sum pipeline computing the clamped duty, followed by
// the result queue. Items are issued only when the queue has room for them.
// ============================================================================
module pisc_back (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire pisc_pkg::t_cfg                 i_cfg,
    input  wire                                 i_work_valid,
    input  wire pisc_pkg::t_work                i_work,
    output logic                                o_work_pop,
    input  wire                                 i_pop,
    output logic                                o_empty,
    output logic [pisc_pkg::DUTY_W-1:0]         o_duty
);

    localparam int PK_W  = pisc_pkg::GAIN_W + 1 + pisc_pkg::ERR_W;
    localparam int HI_W  = pisc_pkg::SUM_W - pisc_pkg::FRAC_W;
    localparam int PH_W  = pisc_pkg::GAIN_W + 1 + HI_W;
    localparam int PL_W  = pisc_pkg::GAIN_W + pisc_pkg::FRAC_W;
    localparam int ACC_W = PL_W + 2;
    localparam int Q_W   = ACC_W - pisc_pkg::FRAC_W;
    localparam int D_W   = PH_W + 3;

    logic                                   r_va;
    logic                                   r_vb;
    logic signed [PK_W-1:0]                 r_pk;
    logic signed [PH_W-1:0]                 r_ph_a;
    logic [PL_W-1:0]                        r_pl;
    logic signed [PH_W-1:0]                 r_ph_b;
    logic signed [Q_W-1:0]                  r_q;

    logic signed [pisc_pkg::GAIN_W:0]       w_kp_s;
    logic signed [pisc_pkg::GAIN_W:0]       w_ki_s;
    logic signed [HI_W-1:0]                 w_hi;
    logic [pisc_pkg::FRAC_W-1:0]            w_lo;
    logic signed [PK_W-1:0]                 n_pk;
    logic signed [PH_W-1:0]                 n_ph;
    logic [PL_W-1:0]                        n_pl;
    logic signed [ACC_W-1:0]                w_acc;
    logic signed [D_W-1:0]                  w_duty;
    logic [pisc_pkg::DUTY_W-1:0]            n_duty;

    logic [pisc_pkg::DUTY_W-1:0]            r_outq [pisc_pkg::OUT_DEPTH];
    logic [pisc_pkg::OUT_AW-1:0]            r_wr_ptr;
    logic [pisc_pkg::OUT_AW-1:0]            r_rd_ptr;
    logic [pisc_pkg::OUT_CW-1:0]            r_count;
    logic [pisc_pkg::OUT_CW-1:0]            w_used;
    logic                                   w_pop;

    // Room is reserved for everything already in the pipeline.
    assign w_used     = r_count + {{(pisc_pkg::OUT_CW-1){1'b0}}, r_va}
                                + {{(pisc_pkg::OUT_CW-1){1'b0}}, r_vb};
    assign o_work_pop = i_work_valid && (w_used < pisc_pkg::OUT_CW'(pisc_pkg::OUT_DEPTH));
    assign o_empty    = (r_count == '0);
    assign o_duty     = r_outq[r_rd_ptr];
    assign w_pop      = i_pop & ~o_empty;

    // Stage A: split the sum into signed high and unsigned low parts; form the products.
    always_comb begin
        w_kp_s = $signed({1'b0, i_cfg.kp});
        w_ki_s = $signed({1'b0, i_cfg.ki});
        w_hi   = i_work.sum[pisc_pkg::SUM_W-1:pisc_pkg::FRAC_W];
        w_lo   = i_work.sum[pisc_pkg::FRAC_W-1:0];
        n_pk   = w_kp_s * i_work.err;
        n_ph   = w_ki_s * w_hi;
        n_pl   = i_cfg.ki * w_lo;
    end

    // Stage B: fractional part sum, floored by an arithmetic shift.
    assign w_acc = $signed({2'b00, r_pl})
                 + $signed({{(ACC_W-PK_W){r_pk[PK_W-1]}}, r_pk});

    // Result: an inverted range yields out_max above out_min and out_min otherwise.
    always_comb begin
        w_duty = $signed({{(D_W-PH_W){r_ph_b[PH_W-1]}}, r_ph_b})
               + $signed({{(D_W-Q_W){r_q[Q_W-1]}}, r_q});
        n_duty = w_duty[pisc_pkg::DUTY_W-1:0];
        if (w_duty >= $signed({{(D_W-pisc_pkg::LIM_W){1'b0}}, i_cfg.out_max})) begin
            n_duty = i_cfg.out_max;
        end
        if (w_duty <= $signed({{(D_W-pisc_pkg::LIM_W){1'b0}}, i_cfg.out_min})) begin
            n_duty = i_cfg.out_min;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va     <= 1'b0;
            r_vb     <= 1'b0;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_va <= o_work_pop;
            r_vb <= r_va;
            if (r_vb) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (r_vb && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!r_vb && w_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_work_pop) begin
            r_pk   <= n_pk;
            r_ph_a <= n_ph;
            r_pl   <= n_pl;
        end
        if (r_va) begin
            r_ph_b <= r_ph_a;
            r_q    <= w_acc[ACC_W-1:pisc_pkg::FRAC_W];
        end
        if (r_vb) begin
            r_outq[r_wr_ptr] <= n_duty;
        end
    end

endmodule
`default_nettype wire
